// File: design/cau_pkg.sv
// Shared constants and types for the complex arithmetic unit.
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_ADD = 2'd0;
	localparam op_t OP_SUB = 2'd1;
	localparam op_t OP_MUL = 2'd2;
	localparam op_t OP_DIV = 2'd3;

	localparam status_t ST_OK  = 2'd0;
	localparam status_t ST_SAT = 2'd1;
	localparam status_t ST_DZ  = 2'd2;

endpackage

// File: design/complex_arithmetic_unit.sv
// Pipelined complex add, subtract, multiply and divide in signed fixed point.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | sink      | in_valid / in_stall  | operation, a_real, a_imag, b_real, b_imag
//  out     | source    | out_valid/ out_stall | out_real, out_imag, status
//
//  One transaction may enter every cycle while the output is not stalled; the restoring
//  divider settles one quotient bit per stage.
//  Reset (arst_n low) clears the valid bit of every stage; payload is not reset.
//  A stall on the output freezes the whole pipeline; in_stall follows it in the
//  same cycle unless the output register is empty, so nothing is dropped or repeated.
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  cau_pkg::op_t                 operation,
	input  logic signed [DATA_WIDTH-1:0] a_real,
	input  logic signed [DATA_WIDTH-1:0] a_imag,
	input  logic signed [DATA_WIDTH-1:0] b_real,
	input  logic signed [DATA_WIDTH-1:0] b_imag,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] out_real,
	output logic signed [DATA_WIDTH-1:0] out_imag,
	output cau_pkg::status_t             status
);
	import cau_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;          // one product
	localparam int SW = 2 * W + 2;      // signed working value
	localparam int MW = 2 * W + 1;      // magnitude of a product sum
	localparam int NQ = W + 1;          // quotient bits kept
	localparam int RW = 3 * W + F + 2;  // dividend and shifted divisor
	localparam logic signed [SW-1:0] SMAX = signed'((SW'(1) << (W - 1)) - SW'(1));
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	// Advance everything unless the output holds a transaction that is stalled.
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Stage 1: six products, add and subtract.
	logic                 vld_s1;
	op_t                  op_s1;
	logic signed [PW-1:0] arbr_s1, aibi_s1, arbi_s1, aibr_s1, brbr_s1, bibi_s1;
	logic signed [W:0]    sum_r_s1, sum_i_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= operation;
			arbr_s1 <= a_real * b_real;
			aibi_s1 <= a_imag * b_imag;
			arbi_s1 <= a_real * b_imag;
			aibr_s1 <= a_imag * b_real;
			brbr_s1 <= b_real * b_real;
			bibi_s1 <= b_imag * b_imag;
			if (operation == OP_SUB) begin
				sum_r_s1 <= (W+1)'(a_real) - (W+1)'(b_real);
				sum_i_s1 <= (W+1)'(a_imag) - (W+1)'(b_imag);
			end else begin
				sum_r_s1 <= (W+1)'(a_real) + (W+1)'(b_real);
				sum_i_s1 <= (W+1)'(a_imag) + (W+1)'(b_imag);
			end
		end
	end

	// Stage 2: product sums, rescale for multiply, sign and magnitude for divide.
	logic                 vld_s2;
	op_t                  op_s2;
	logic signed [SW-1:0] val_s2 [0:1];
	logic                 neg_s2 [0:1];
	logic [MW-1:0]        mag_s2 [0:1];
	logic [MW-1:0]        den_s2;

	logic signed [SW-1:0] mr_c, mi_c, nr_c, ni_c;
	logic [MW-1:0]        den_c;

	always_comb begin
		mr_c  = SW'(arbr_s1) - SW'(aibi_s1);
		mi_c  = SW'(arbi_s1) + SW'(aibr_s1);
		nr_c  = SW'(arbr_s1) + SW'(aibi_s1);
		ni_c  = SW'(aibr_s1) - SW'(arbi_s1);
		den_c = MW'(brbr_s1) + MW'(bibi_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2  <= op_s1;
			den_s2 <= den_c;
			if (op_s1 == OP_MUL) begin
				val_s2[0] <= mr_c >>> F;
				val_s2[1] <= mi_c >>> F;
			end else begin
				val_s2[0] <= SW'(sum_r_s1);
				val_s2[1] <= SW'(sum_i_s1);
			end
			neg_s2[0] <= nr_c[SW-1];
			neg_s2[1] <= ni_c[SW-1];
			mag_s2[0] <= nr_c[SW-1] ? MW'(-nr_c) : MW'(nr_c);
			mag_s2[1] <= ni_c[SW-1] ? MW'(-ni_c) : MW'(ni_c);
		end
	end

	// Stage 3: restoring divider, entry 0 checks overflow, entry k settles one bit.
	logic                 vld_s3 [0:NQ];
	op_t                  op_s3  [0:NQ];
	logic signed [SW-1:0] val_s3 [0:NQ][0:1];
	logic                 neg_s3 [0:NQ][0:1];
	logic                 ovf_s3 [0:NQ][0:1];
	logic [RW-1:0]        rem_s3 [0:NQ-1][0:1];
	logic [NQ-1:0]        quo_s3 [0:NQ][0:1];
	logic [MW-1:0]        den_s3 [0:NQ];

	logic [RW-1:0] dvd_c [0:1];
	logic [RW-1:0] dtop_c;

	always_comb begin
		dtop_c = RW'(den_s2) << NQ;
		for (int l = 0; l < 2; l++) begin
			dvd_c[l] = RW'(mag_s2[l]) << F;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3[0] <= 1'b0;
		end else if (adv) begin
			vld_s3[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3[0]  <= op_s2;
			den_s3[0] <= den_s2;
			for (int l = 0; l < 2; l++) begin
				val_s3[0][l] <= val_s2[l];
				neg_s3[0][l] <= neg_s2[l];
				ovf_s3[0][l] <= dvd_c[l] >= dtop_c;
				rem_s3[0][l] <= dvd_c[l];
				quo_s3[0][l] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= NQ; k++) begin : g_div
		localparam int BIT = NQ - k;
		logic [RW-1:0] dsh;
		logic          take [0:1];

		always_comb begin
			dsh = RW'(den_s3[k-1]) << BIT;
			for (int l = 0; l < 2; l++) begin
				take[l] = rem_s3[k-1][l] >= dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s3[k] <= 1'b0;
			end else if (adv) begin
				vld_s3[k] <= vld_s3[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				op_s3[k]  <= op_s3[k-1];
				den_s3[k] <= den_s3[k-1];
				for (int l = 0; l < 2; l++) begin
					val_s3[k][l] <= val_s3[k-1][l];
					neg_s3[k][l] <= neg_s3[k-1][l];
					ovf_s3[k][l] <= ovf_s3[k-1][l];
					quo_s3[k][l] <= {quo_s3[k-1][l][NQ-2:0], take[l]};
				end
			end
		end

		// The last bit needs no remainder after it.
		if (k < NQ) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					for (int l = 0; l < 2; l++) begin
						rem_s3[k][l] <= take[l] ? rem_s3[k-1][l] - dsh : rem_s3[k-1][l];
					end
				end
			end
		end
	end

	// Stage 4: pick the result, saturate, set status.
	logic signed [SW-1:0] fin_c [0:1];
	logic signed [DATA_WIDTH-1:0] sat_c [0:1];
	logic                 any_sat_c;
	logic                 dz_c;

	always_comb begin
		dz_c      = (op_s3[NQ] == OP_DIV) && (den_s3[NQ] == '0);
		any_sat_c = 1'b0;
		for (int l = 0; l < 2; l++) begin
			if (op_s3[NQ] == OP_DIV) begin
				fin_c[l] = ovf_s3[NQ][l] ? (SW'(1) << W) : SW'(quo_s3[NQ][l]);
				if (neg_s3[NQ][l]) begin
					fin_c[l] = -fin_c[l];
				end
			end else begin
				fin_c[l] = val_s3[NQ][l];
			end
			if (fin_c[l] > SMAX) begin
				sat_c[l]  = W'(SMAX);
				any_sat_c = 1'b1;
			end else if (fin_c[l] < SMIN) begin
				sat_c[l]  = W'(SMIN);
				any_sat_c = 1'b1;
			end else begin
				sat_c[l] = W'(fin_c[l]);
			end
		end
	end

	logic                         vld_s4;
	logic signed [DATA_WIDTH-1:0] re_s4, im_s4;
	status_t                      st_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3[NQ];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dz_c) begin
				re_s4 <= '0;
				im_s4 <= '0;
				st_s4 <= ST_DZ;
			end else begin
				re_s4 <= sat_c[0];
				im_s4 <= sat_c[1];
				st_s4 <= any_sat_c ? ST_SAT : ST_OK;
			end
		end
	end

	assign out_valid = vld_s4;
	assign out_real  = re_s4;
	assign out_imag  = im_s4;
	assign status    = st_s4;

endmodule

// File: tb/complex_arithmetic_unit_tb.sv
// Self-checking testbench for the complex arithmetic unit with bursty input and output stall.
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	localparam int W = 16;
	localparam int F = 8;
	localparam int LATENCY = W + 5;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		op_t            op;
		logic [W-1:0]   ar;
		logic [W-1:0]   ai;
		logic [W-1:0]   br;
		logic [W-1:0]   bi;
	} operands_t;

	typedef struct packed {
		logic [W-1:0] re;
		logic [W-1:0] im;
		status_t      st;
	} cplx_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	op_t                 operation;
	logic signed [W-1:0] a_real, a_imag, b_real, b_imag;
	logic                out_valid;
	logic                out_stall;
	logic signed [W-1:0] out_real, out_imag;
	status_t             status;

	operands_t    pending_ops[$];
	cplx_result_t expected_results[$];
	int           errors = 0;
	longint       cycles = 0;
	bit           hold_off = 0;
	bit           stim_done = 0;
	bit           in_taken = 0;
	int           burst_left = 0;
	int           gap_left = 0;
	int           stall_mode = 0;
	int           stall_phase = 0;

	complex_arithmetic_unit #(.DATA_WIDTH(W), .FRAC_BITS(F)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .a_real(a_real), .a_imag(a_imag),
		.b_real(b_real), .b_imag(b_imag),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_real(out_real), .out_imag(out_imag), .status(status)
	);

	// Clamp a wide signed value to the W-bit range, flagging clipping.
	function automatic logic [W-1:0] clip(input logic signed [95:0] v, inout bit sat);
		logic signed [95:0] hi;
		logic signed [95:0] lo;
		hi = (96'sd1 <<< (W - 1)) - 1;
		lo = -(96'sd1 <<< (W - 1));
		if (v > hi) begin
			sat = 1;
			return hi[W-1:0];
		end
		if (v < lo) begin
			sat = 1;
			return lo[W-1:0];
		end
		return v[W-1:0];
	endfunction

	// Work out the complex result of one operand set.
	function automatic cplx_result_t complex_result(input operands_t t);
		logic signed [95:0] ar, ai, br, bi, nre, nim, den, qre, qim;
		cplx_result_t r;
		bit sat;
		ar = $signed(t.ar);
		ai = $signed(t.ai);
		br = $signed(t.br);
		bi = $signed(t.bi);
		sat = 0;
		case (t.op)
			OP_ADD: begin
				nre = ar + br;
				nim = ai + bi;
			end
			OP_SUB: begin
				nre = ar - br;
				nim = ai - bi;
			end
			OP_MUL: begin
				// arithmetic shift floors toward minus infinity
				nre = (ar * br - ai * bi) >>> F;
				nim = (ar * bi + ai * br) >>> F;
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.re = '0;
					r.im = '0;
					r.st = ST_DZ;
					return r;
				end
				// signed division truncates toward zero
				qre = ((ar * br + ai * bi) <<< F) / den;
				qim = ((ai * br - ar * bi) <<< F) / den;
				nre = qre;
				nim = qim;
			end
		endcase
		r.re = clip(nre, sat);
		r.im = clip(nim, sat);
		r.st = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	function automatic logic [W-1:0] pick_part();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return '0;
			3: return 16'(signed'($urandom_range(0, 1536)) - 768);
			4, 5: return 16'(signed'($urandom_range(0, 8192)) - 4096);
			default: return W'($urandom);
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// Fill the queue: corner operand sets first, then random traffic.
	initial begin
		operands_t t;
		logic [W-1:0] corners[4];
		corners = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
		for (int o = 0; o < 4; o++) begin
			for (int k = 0; k < 4; k++) begin
				t.op = op_t'(o);
				t.ar = corners[k];
				t.ai = corners[(k + 1) % 4];
				t.br = corners[(k + 3) % 4];
				t.bi = corners[k];
				pending_ops.push_back(t);
			end
		end
		// zero divisor, divide by one and by the smallest step, and one multiply
		pending_ops.push_back('{OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000});
		pending_ops.push_back('{OP_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0000});
		pending_ops.push_back('{OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000});
		pending_ops.push_back('{OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001});
		for (int n = 0; n < 1650; n++) begin
			t.op = op_t'($urandom_range(0, 3));
			t.ar = pick_part();
			t.ai = pick_part();
			t.br = pick_part();
			t.bi = pick_part();
			if (t.op == OP_DIV && $urandom_range(0, 30) == 0) begin
				t.br = '0;
				t.bi = '0;
			end
			pending_ops.push_back(t);
			// let the pipeline drain once, mid-run
			if (n == 800) begin
				wait (pending_ops.size() == 1);
				hold_off = 1;
				wait (expected_results.size() == 0);
				@(negedge clk);
				hold_off = 0;
			end
		end
		stim_done = 1;
	end

	// Driver: present operands at the falling edge in bursts with gaps.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 0;
			operation <= OP_ADD;
			a_real    <= '0;
			a_imag    <= '0;
			b_real    <= '0;
			b_imag    <= '0;
		end else begin
			// hold a stalled transaction unchanged
			if (!in_valid || in_taken) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
				if (gap_left > 0 && burst_left == 0) begin
					gap_left--;
					in_valid <= 0;
				end else if (hold_off || pending_ops.size() == 0) begin
					in_valid <= 0;
				end else begin
					operands_t t;
					t = pending_ops.pop_front();
					if (burst_left > 0)
						burst_left--;
					in_valid  <= 1;
					operation <= t.op;
					a_real    <= t.ar;
					a_imag    <= t.ai;
					b_real    <= t.br;
					b_imag    <= t.bi;
				end
			end
		end
	end

	// Receiver stall pattern: switch between free, periodic and random modes.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if ($urandom_range(0, 99) == 0)
				stall_mode = $urandom_range(0, 2);
			stall_phase++;
			case (stall_mode)
				0: out_stall <= 0;
				1: out_stall <= (stall_phase % 5) < 2;
				default: out_stall <= $urandom_range(0, 2) == 0;
			endcase
		end
	end

	// Monitor: record accepted inputs and check accepted results.
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (arst_n) begin
			cycles++;
			if (in_valid && !in_stall)
				expected_results.push_back(complex_result(
					'{operation, a_real, a_imag, b_real, b_imag}));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result re=%h im=%h st=%0d", $time,
						out_real, out_imag, status);
					errors++;
				end else begin
					cplx_result_t e;
					e = expected_results.pop_front();
					if (out_real !== e.re) begin
						$display("%0t: out_real expected %h actual %h", $time, e.re, out_real);
						errors++;
					end
					if (out_imag !== e.im) begin
						$display("%0t: out_imag expected %h actual %h", $time, e.im, out_imag);
						errors++;
					end
					if (status !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time, e.st, status);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: stop at a generous cycle count.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("[complex_arithmetic_unit] ERROR");
			$finish;
		end
	end

	// End of run: drain, let the pipeline settle, then report.
	initial begin
		wait (stim_done && pending_ops.size() == 0);
		@(posedge clk);
		wait (!in_valid && expected_results.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("[complex_arithmetic_unit] OK");
		else
			$display("[complex_arithmetic_unit] ERROR");
		$finish;
	end

endmodule
